@@ rtl/irf_pkg.sv @@
package irf_pkg;

    typedef enum logic [2:0] {
        V_LOCAL      = 3'd0,
        V_FORWARD    = 3'd1,
        V_TTL_ERR    = 3'd2,
        V_NO_ROUTE   = 3'd3,
        V_TABLE_FULL = 3'd4
    } verdict_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic        valid;
        verdict_t    verdict;
        logic [31:0] dest;
        logic [31:0] hop;
    } token_t;

    // route entry broadcast to the cells on an add
    typedef struct packed {
        logic [31:0] dest;
        logic [5:0]  len;
        logic [31:0] hop;
    } route_t;

    localparam logic [5:0]  MAX_PREFIX = 6'd32;
    localparam logic [3:0]  WIDX_IHL   = 4'd0;
    localparam logic [3:0]  WIDX_TTL   = 4'd2;
    localparam logic [3:0]  WIDX_DEST  = 4'd4;
    localparam logic [3:0]  WIDX_MAX   = 4'd15;
    localparam logic [16:0] CSUM_MOD   = 17'd65535;
    localparam logic [15:0] CSUM_ONES  = 16'hffff;

    // shifts of 32 or more give zero, so lengths 0 and 32+ fall out naturally
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hffff_ffff >> len);
    endfunction

    // (sum + half) mod 65535, with sum already below 65535
    function automatic logic [15:0] csum_fold(input logic [15:0] sum,
                                              input logic [15:0] half);
        logic [16:0] s;
        s = {1'b0, sum} + {1'b0, half};
        if (s >= CSUM_MOD)
            csum_fold = 16'(s - CSUM_MOD);
        else
            csum_fold = s[15:0];
    endfunction

endpackage

@@ rtl/ipv4_route_forward.sv @@
// IPv4 forwarding decision over a table of routes held in a row of cells.
// Input: an item is transferred on a clock edge with start high and busy low.
//   mode 0 adds a route (word = destination, route_prefix_len, route_next_hop);
//   mode 1 delivers one header word, last marks the final word of a packet.
// Config: local_address is written by cfg_we / cfg_wdata; the user must write
//   it only while idle, and the block itself does not enforce this.
// Output: done is high for one cycle with verdict, next_hop, new_ttl and
//   new_checksum; the receiver must take it, there is no stall.
// Timing: a new item may follow right after a route add or a non-final header
//   word. A route add into a full table shows V_TABLE_FULL in the next cycle.
//   A final header word launches a lookup token that walks the cell row one
//   cell per cycle; the verdict is registered through query_reg, each cell's
//   token register and done_reg, and busy stays high until it is shown.
// Reset: the route table is emptied (count cleared), packet state and
//   local_address go to zero, no result is pending.
module ipv4_route_forward #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] word,
    input  logic        last,
    input  logic [5:0]  route_prefix_len,
    input  logic [31:0] route_next_hop,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output logic [2:0]  verdict,
    output logic [31:0] next_hop,
    output logic [7:0]  new_ttl,
    output logic [15:0] new_checksum
);
    import irf_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CW-1:0] route_count_reg, route_count_next;
    logic [3:0]    word_index_reg, word_index_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    held_ttl_reg, held_ttl_next;
    logic [31:0]   held_dest_reg, held_dest_next;
    logic [3:0]    held_ihl_reg, held_ihl_next;
    logic [31:0]   local_address_reg;
    token_t        query_reg, query_next;
    logic [7:0]    pkt_ttl_reg, pkt_ttl_next;
    logic [15:0]   pkt_sum_reg, pkt_sum_next;
    logic          done_reg, done_next;
    verdict_t      verdict_reg, verdict_next;
    logic [31:0]   next_hop_reg, next_hop_next;
    logic [7:0]    new_ttl_reg, new_ttl_next;
    logic [15:0]   new_checksum_reg, new_checksum_next;

    token_t                 tok [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] cell_busy;
    route_t                 add_route;
    logic                   accept;
    logic                   table_full;
    logic                   add_en;
    logic [5:0]             len_clamp;
    logic [3:0]             ihl_eff;
    logic [7:0]             ttl_eff;
    logic [31:0]            dest_eff;
    logic [15:0]            sum_hdr;
    verdict_t               pre_verdict;

    assign tok[0] = query_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            irf_cell #(
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .route_count (route_count_reg),
                .add_en      (add_en),
                .add_route   (add_route),
                .tok_in      (tok[gi]),
                .tok_out     (tok[gi+1])
            );
            assign cell_busy[gi] = tok[gi+1].valid;
        end
    endgenerate

    assign busy       = query_reg.valid | (|cell_busy);
    assign accept     = start && !busy;
    assign table_full = route_count_reg == CW'(TABLE_DEPTH);
    assign add_en     = accept && !mode && !table_full;

    assign len_clamp      = (route_prefix_len > MAX_PREFIX) ? MAX_PREFIX : route_prefix_len;
    assign add_route.dest = word & prefix_mask(len_clamp);
    assign add_route.len  = len_clamp;
    assign add_route.hop  = route_next_hop;

    // header fields as they stand once the current word is included
    assign ihl_eff  = (word_index_reg == WIDX_IHL)  ? word[27:24] : held_ihl_reg;
    assign ttl_eff  = (word_index_reg == WIDX_TTL)  ? word[31:24] : held_ttl_reg;
    assign dest_eff = (word_index_reg == WIDX_DEST) ? word        : held_dest_reg;

    always_comb
    begin
        sum_hdr = sum_reg;
        if (word_index_reg < ihl_eff)
        begin
            if (word_index_reg == WIDX_TTL)
                // old checksum halfword is skipped, TTL enters decremented
                sum_hdr = csum_fold(sum_reg, {word[31:24] - 8'd1, word[23:16]});
            else
                sum_hdr = csum_fold(csum_fold(sum_reg, word[31:16]), word[15:0]);
        end
    end

    always_comb
    begin
        if (dest_eff == local_address_reg)
            pre_verdict = V_LOCAL;
        else if (ttl_eff == 8'd0)
            pre_verdict = V_TTL_ERR;
        else
            pre_verdict = V_NO_ROUTE;
    end

    always_comb
    begin
        route_count_next  = route_count_reg;
        word_index_next   = word_index_reg;
        sum_next          = sum_reg;
        held_ttl_next     = held_ttl_reg;
        held_dest_next    = held_dest_reg;
        held_ihl_next     = held_ihl_reg;
        query_next        = '0;
        pkt_ttl_next      = pkt_ttl_reg;
        pkt_sum_next      = pkt_sum_reg;
        done_next         = 1'b0;
        verdict_next      = verdict_reg;
        next_hop_next     = next_hop_reg;
        new_ttl_next      = new_ttl_reg;
        new_checksum_next = new_checksum_reg;

        if (add_en)
            route_count_next = route_count_reg + CW'(1);

        if (accept && mode)
        begin
            if (last)
            begin
                word_index_next    = '0;
                sum_next           = '0;
                held_ttl_next      = '0;
                held_dest_next     = '0;
                held_ihl_next      = '0;
                query_next.valid   = 1'b1;
                query_next.verdict = pre_verdict;
                query_next.dest    = dest_eff;
                query_next.hop     = '0;
                pkt_ttl_next       = ttl_eff;
                pkt_sum_next       = sum_hdr;
            end
            else
            begin
                sum_next       = sum_hdr;
                held_ttl_next  = ttl_eff;
                held_dest_next = dest_eff;
                held_ihl_next  = ihl_eff;
                if (word_index_reg != WIDX_MAX)
                    word_index_next = word_index_reg + 4'd1;
            end
        end

        if (accept && !mode && table_full)
        begin
            done_next         = 1'b1;
            verdict_next      = V_TABLE_FULL;
            next_hop_next     = '0;
            new_ttl_next      = '0;
            new_checksum_next = '0;
        end
        else if (tok[TABLE_DEPTH].valid)
        begin
            done_next    = 1'b1;
            verdict_next = tok[TABLE_DEPTH].verdict;
            if (tok[TABLE_DEPTH].verdict == V_FORWARD)
            begin
                next_hop_next     = tok[TABLE_DEPTH].hop;
                new_ttl_next      = pkt_ttl_reg - 8'd1;
                new_checksum_next = CSUM_ONES - pkt_sum_reg;
            end
            else
            begin
                next_hop_next     = '0;
                new_ttl_next      = '0;
                new_checksum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_count_reg   <= '0;
            word_index_reg    <= '0;
            sum_reg           <= '0;
            held_ttl_reg      <= '0;
            held_dest_reg     <= '0;
            held_ihl_reg      <= '0;
            local_address_reg <= '0;
            query_reg         <= '0;
            pkt_ttl_reg       <= '0;
            pkt_sum_reg       <= '0;
            done_reg          <= 1'b0;
            verdict_reg       <= V_LOCAL;
            next_hop_reg      <= '0;
            new_ttl_reg       <= '0;
            new_checksum_reg  <= '0;
        end
        else
        begin
            route_count_reg  <= route_count_next;
            word_index_reg   <= word_index_next;
            sum_reg          <= sum_next;
            held_ttl_reg     <= held_ttl_next;
            held_dest_reg    <= held_dest_next;
            held_ihl_reg     <= held_ihl_next;
            if (cfg_we)
                local_address_reg <= cfg_wdata;
            query_reg        <= query_next;
            pkt_ttl_reg      <= pkt_ttl_next;
            pkt_sum_reg      <= pkt_sum_next;
            done_reg         <= done_next;
            verdict_reg      <= verdict_next;
            next_hop_reg     <= next_hop_next;
            new_ttl_reg      <= new_ttl_next;
            new_checksum_reg <= new_checksum_next;
        end
    end

    assign done         = done_reg;
    assign verdict      = verdict_reg;
    assign next_hop     = next_hop_reg;
    assign new_ttl      = new_ttl_reg;
    assign new_checksum = new_checksum_reg;

endmodule

@@ rtl/irf_cell.sv @@
module irf_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [CW-1:0]   route_count,
    input  logic            add_en,
    input  irf_pkg::route_t add_route,
    input  irf_pkg::token_t tok_in,
    output irf_pkg::token_t tok_out
);
    import irf_pkg::*;

    logic [31:0] dest_reg;
    logic [5:0]  len_reg;
    logic [31:0] hop_reg;
    token_t      tok_reg;
    token_t      tok_next;
    logic        in_table;
    logic        hit;

    assign in_table = CW'(IDX) < route_count;
    assign hit      = in_table && ((tok_in.dest & prefix_mask(len_reg)) == dest_reg);

    always_ff @(posedge clk)
    begin
        if (add_en && route_count == CW'(IDX))
        begin
            dest_reg <= add_route.dest;
            len_reg  <= add_route.len;
            hop_reg  <= add_route.hop;
        end
    end

    // first matching entry wins: later cells see the verdict already set
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.verdict == V_NO_ROUTE && hit)
        begin
            tok_next.verdict = V_FORWARD;
            tok_next.hop     = hop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

endmodule
